[design/oal_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_pkg: shared types and codes for the ordered array list engine
// Opcodes, status codes, cell update modes and the structs that run along
// the row of cells.
// ----------------------------------------------------------------------------
package oal_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int POS_W     = 8;
  localparam int STAT_W    = 2;
  localparam int RIDX_W    = 7;
  localparam int CNTO_W    = 8;
  localparam int DEPTH_DEF = 128;

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BADPOS   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_HOLD   = 2'd0;
  localparam mode_t MODE_WRITE  = 2'd1;
  localparam mode_t MODE_INSERT = 2'd2;
  localparam mode_t MODE_DELETE = 2'd3;

  // Broadcast to every cell
  typedef struct packed {
    mode_t             mode;
    logic              search;
    logic [DATA_W-1:0] value;
  } bcast_t;

  // Scan token walking the row, one cell per cycle
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [RIDX_W-1:0] idx;
    logic [DATA_W-1:0] value;
  } probe_t;

endpackage

[design/oal_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_cell: one slot of the list
// Holds one entry, takes writes, shifts with neighbours on insert/delete,
// and passes the scan token on, capturing a hit if none was taken upstream.
// ----------------------------------------------------------------------------
module oal_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 7,
  parameter int CNT_W = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  oal_pkg::bcast_t             bcast,
  input  logic [IDX_W-1:0]            tgt,
  input  logic [CNT_W-1:0]            cnt,
  input  logic [oal_pkg::DATA_W-1:0]  left_entry,
  input  logic [oal_pkg::DATA_W-1:0]  right_entry,
  output logic [oal_pkg::DATA_W-1:0]  entry,
  input  oal_pkg::probe_t             prb_in,
  output oal_pkg::probe_t             prb_out
);
  import oal_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic [DATA_W-1:0] entry_next;
  logic              hit;

  always_comb begin
    entry_next = entry;
    case (bcast.mode)
      MODE_WRITE: begin
        if (MY_IDX == tgt) entry_next = bcast.value;
      end
      MODE_INSERT: begin
        if (MY_IDX == tgt)     entry_next = bcast.value;
        else if (MY_IDX > tgt) entry_next = left_entry;
      end
      MODE_DELETE: begin
        if (MY_IDX >= tgt) entry_next = right_entry;
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // only live entries may hit; read matches on index, search on value
  assign hit = (MY_CNT < cnt) &&
               (bcast.search ? (entry == bcast.value) : (MY_IDX == tgt));

  always_ff @(posedge clk) begin
    if (rst) begin
      prb_out.valid <= 1'b0;
    end else begin
      prb_out.valid <= prb_in.valid;
    end
    if (prb_in.found || !hit) begin
      prb_out.found <= prb_in.found;
      prb_out.idx   <= prb_in.idx;
      prb_out.value <= prb_in.value;
    end else begin
      prb_out.found <= 1'b1;
      prb_out.idx   <= RIDX_W'(INDEX);
      prb_out.value <= bcast.search ? bcast.value : entry;
    end
  end

endmodule

[design/ordered_array_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_engine: ordered list of signed 32-bit entries
// Row of DEPTH cells with a small controller; edits shift in the accept
// cycle, lookups walk a token down the row.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_ready) carries opcode, position, operand_value.
//   Output beat (out_valid/out_ready) carries status, result_index,
//   result_value, entry_count; one output beat per input beat, in order.
//   Clear, append, insert, delete, unused opcodes and a read at a bad
//   position finish in the accept cycle: the result is registered and shown
//   on the next cycle; with out_ready high they sustain one beat per cycle.
//   Search and a valid read send a token down the row of cells, one cell a
//   cycle: the result is registered once the token leaves the last cell,
//   and the next beat is taken once it is. The walk grows with the row.
//   A new beat is taken only while the output register is empty or being
//   drained in that cycle; a stalled receiver therefore holds off the input.
//   Reset empties the list (count zero) and drops any pending result; entry
//   contents are left as they are and only live entries are ever seen.
// ----------------------------------------------------------------------------
module ordered_array_list_engine #(
  parameter int DEPTH = oal_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [oal_pkg::OP_W-1:0]    opcode,
  input  logic [oal_pkg::POS_W-1:0]   position,
  input  logic signed [oal_pkg::DATA_W-1:0] operand_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [oal_pkg::STAT_W-1:0]  status,
  output logic [oal_pkg::RIDX_W-1:0]  result_index,
  output logic signed [oal_pkg::DATA_W-1:0] result_value,
  output logic [oal_pkg::CNTO_W-1:0]  entry_count
);
  import oal_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state;
  logic              state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [DATA_W-1:0] key;
  logic [IDX_W-1:0]  tgt_hold;
  logic              search_hold;
  logic [RIDX_W-1:0] pos_hold;
  logic              go;

  logic              accept;
  logic              full;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic [IDX_W-1:0]  tgt_pos;
  logic [IDX_W-1:0]  tgt;
  bcast_t            bc;
  logic              imm_load;
  logic [STAT_W-1:0] imm_status;
  logic              scan_start;
  logic              scan_done;

  logic [DATA_W-1:0] ent [DEPTH];
  probe_t            prb [DEPTH+1];

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_FULL);
  assign pos_c    = CMP_W'(position);
  assign cnt_c    = CMP_W'(count);
  assign tgt_pos  = IDX_W'(position);

  always_comb begin
    bc.mode    = MODE_HOLD;
    bc.search  = search_hold;
    bc.value   = key;
    tgt        = tgt_hold;
    count_next = count;
    imm_load   = 1'b0;
    imm_status = STAT_OK;
    scan_start = 1'b0;
    if (accept) begin
      bc.value = operand_value;
      imm_load = 1'b1;
      case (opcode)
        OP_CLEAR: begin
          count_next = '0;
        end
        OP_APPEND: begin
          if (full) begin
            imm_status = STAT_FULL;
          end else begin
            bc.mode    = MODE_WRITE;
            tgt        = IDX_W'(count);
            count_next = count + CNT_W'(1);
          end
        end
        OP_INSERT: begin
          if (pos_c > cnt_c) begin
            imm_status = STAT_BADPOS;
          end else if (full) begin
            imm_status = STAT_FULL;
          end else begin
            bc.mode    = MODE_INSERT;
            tgt        = tgt_pos;
            count_next = count + CNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (pos_c >= cnt_c) begin
            imm_status = STAT_BADPOS;
          end else begin
            bc.mode    = MODE_DELETE;
            tgt        = tgt_pos;
            count_next = count - CNT_W'(1);
          end
        end
        OP_SEARCH: begin
          imm_load   = 1'b0;
          scan_start = 1'b1;
        end
        OP_READ: begin
          if (pos_c >= cnt_c) begin
            imm_status = STAT_BADPOS;
          end else begin
            imm_load   = 1'b0;
            scan_start = 1'b1;
          end
        end
        default: imm_status = STAT_OK;
      endcase
    end
  end

  assign scan_done = prb[DEPTH].valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (scan_start) state_next = S_SCAN;
      S_SCAN:  if (scan_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      go    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      go    <= scan_start;
    end
  end

  // lookup operands held for the length of the walk
  always_ff @(posedge clk) begin
    if (accept) begin
      key         <= operand_value;
      tgt_hold    <= tgt_pos;
      search_hold <= (opcode == OP_SEARCH);
      pos_hold    <= position[RIDX_W-1:0];
    end
  end

  assign prb[0] = '{valid: go, found: 1'b0, idx: '0, value: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    oal_cell #(
      .INDEX (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .bcast       (bc),
      .tgt         (tgt),
      .cnt         (count),
      .left_entry  (ent[(i > 0) ? i - 1 : i]),
      .right_entry (ent[(i < DEPTH - 1) ? i + 1 : i]),
      .entry       (ent[i]),
      .prb_in      (prb[i]),
      .prb_out     (prb[i+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (imm_load || scan_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (imm_load) begin
      status       <= imm_status;
      result_index <= position[RIDX_W-1:0];
      result_value <= '0;
      entry_count  <= CNTO_W'(count_next);
    end else if (scan_done) begin
      status       <= prb[DEPTH].found ? STAT_OK : STAT_NOTFOUND;
      result_index <= prb[DEPTH].found ? prb[DEPTH].idx : pos_hold;
      result_value <= prb[DEPTH].found ? prb[DEPTH].value : '0;
      entry_count  <= CNTO_W'(count);
    end
  end

endmodule
